FILE: hdl/cksr_pkg.sv
`default_nettype none

package cksr_pkg;

	// Field widths
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SLOT_W   = 14;
	localparam int unsigned SERVER_W = 8;
	localparam int unsigned CRC_W    = 16;

	// Table geometry: two banks of SLOT_COUNT entries each
	localparam int unsigned SLOT_COUNT  = 16384;
	localparam int unsigned TABLE_DEPTH = 2 * SLOT_COUNT;
	localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);

	// CRC constants
	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
	localparam logic [CRC_W-1:0] CRC_INV  = 16'hFFFF;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_KEY     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CONFIRM = 2'd2;

	// Fold one byte into a reflected CRC, one bit per step
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/cksr_ram.sv
`default_nettype none

module cksr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on we, registered read on en
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (en) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/crc16_key_slot_router.sv
`default_nettype none

// Key-to-server router. One beat is taken per clock while busy is low (busy
// never rises in this design, so a beat may come in every cycle). Key bytes
// (mode 0) feed a reflected CRC-16, poly 0xA001, init 0; the byte with last
// set closes the key. In the cycle after that beat, done pulses for exactly one
// cycle with slot = ~CRC[13:0] and the server read from the active bank; the
// receiver cannot stall, so it must take the result in that cycle. The
// delay is the registered read of the single-port slot table RAM, which
// holds both banks. Table writes (mode 1) go to the active bank until the
// first upload completes (a write with last set) and to the staging bank
// after; confirm (mode 2) swaps the banks. table_ready is low, and server
// is not meaningful, until the first upload has completed. Table entries
// are undefined until written; there is no clearing pass after reset.
module crc16_key_slot_router
	import cksr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [BYTE_W-1:0]   key_byte,
	input  wire logic                last,
	input  wire logic [SLOT_W-1:0]   slot_index,
	input  wire logic [SERVER_W-1:0] slot_value,
	output logic                     done,
	output logic      [SLOT_W-1:0]   slot,
	output logic      [SERVER_W-1:0] server,
	output logic                     table_ready
);

	logic                  accept;
	logic                  key_beat;
	logic                  key_end;
	logic                  wr_beat;
	logic                  wr_in_range;
	logic                  rd_in_range;
	logic                  wr_bank;
	logic [CRC_W-1:0]      crc_next;
	logic [CRC_W-1:0]      crc_inv;
	logic [SLOT_W-1:0]     slot_next;
	logic [TABLE_AW-1:0]   ram_addr;
	logic [SERVER_W-1:0]   ram_rdata;

	logic [CRC_W-1:0]      crc_q;
	logic                  active_bank_q;
	logic                  first_loaded_q;
	logic                  done_s1;
	logic                  ready_s1;
	logic                  in_range_s1;
	logic [SLOT_W-1:0]     slot_s1;

	// The block never stalls: busy is tied low
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Decode the beat
	assign key_beat = accept && (mode == MODE_KEY);
	assign key_end  = key_beat && last;
	assign wr_beat  = accept && (mode == MODE_WRITE);

	// Fold the byte and form the slot
	assign crc_next  = crc_byte(crc_q, key_byte);
	assign crc_inv   = crc_next ^ CRC_INV;
	assign slot_next = crc_inv[SLOT_W-1:0];

	assign rd_in_range = 32'(slot_next) < SLOT_COUNT;
	assign wr_in_range = 32'(slot_index) < SLOT_COUNT;
	assign wr_bank     = first_loaded_q ? !active_bank_q : active_bank_q;

	// Select the table address: lookup in the active bank, write per upload target
	always_comb begin
		if (mode == MODE_WRITE) begin
			ram_addr = wr_bank ? TABLE_AW'(SLOT_COUNT) + TABLE_AW'(slot_index)
			                   : TABLE_AW'(slot_index);
		end else begin
			ram_addr = active_bank_q ? TABLE_AW'(SLOT_COUNT) + TABLE_AW'(slot_next)
			                         : TABLE_AW'(slot_next);
		end
	end

	cksr_ram #(
		.WIDTH (SERVER_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.en    (key_end && rd_in_range),
		.we    (wr_beat && wr_in_range),
		.addr  (ram_addr),
		.wdata (slot_value),
		.rdata (ram_rdata)
	);

	// Advance the CRC, clear it at key end; track bank state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q          <= '0;
			active_bank_q  <= 1'b0;
			first_loaded_q <= 1'b0;
			done_s1        <= 1'b0;
		end else begin
			done_s1 <= key_end;
			if (key_beat) begin
				crc_q <= last ? '0 : crc_next;
			end
			if (wr_beat && last) begin
				first_loaded_q <= 1'b1;
			end
			if (accept && (mode == MODE_CONFIRM)) begin
				active_bank_q <= !active_bank_q;
			end
		end
	end

	// Hold the result fields alongside the RAM read
	always_ff @(posedge clk) begin
		if (key_end) begin
			slot_s1     <= slot_next;
			in_range_s1 <= rd_in_range;
			ready_s1    <= first_loaded_q && rd_in_range;
		end
	end

	assign done        = done_s1;
	assign slot        = slot_s1;
	assign server      = in_range_s1 ? ram_rdata : '0;
	assign table_ready = ready_s1;

	// A result follows only a closing key beat
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (mode == MODE_KEY) && last))
		else $error("result without a closing key beat");

	// The CRC restarts after each key
	a_crc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == MODE_KEY) && last) |=> (crc_q == '0))
		else $error("CRC not cleared at key end");

	// A ready result implies a completed upload
	a_ready_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_ready) |-> first_loaded_q)
		else $error("table_ready before first upload");

	// Slots past the table give no server
	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (32'(slot) >= SLOT_COUNT)) |-> ((server == '0) && !table_ready))
		else $error("out-of-range slot returned a server");

endmodule

`default_nettype wire

FILE: test/crc16_key_slot_router_checker.sv
module crc16_key_slot_router_checker
	import cksr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [BYTE_W-1:0]   key_byte,
	input  wire logic                last,
	input  wire logic [SLOT_W-1:0]   slot_index,
	input  wire logic [SERVER_W-1:0] slot_value,
	input  wire logic                done,
	input  wire logic [SLOT_W-1:0]   slot,
	input  wire logic [SERVER_W-1:0] server,
	input  wire logic                table_ready,
	output int                       errors,
	output int                       pending
);

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [SERVER_W-1:0] server;
		logic                ready;
	} route_t;

	// Routes still owed by the block, oldest first
	route_t route_q[$];

	// Shadow of both slot-table banks and the routing state
	logic [SERVER_W-1:0] slot_map [2][SLOT_COUNT];
	logic [CRC_W-1:0]    key_crc;
	logic                live_bank;
	logic                upload_done;
	int                  fail_cnt = 0;

	// Reflected CRC, data bit k enters at shift k
	function automatic logic [CRC_W-1:0] fold_key_byte(input logic [CRC_W-1:0] acc,
		input logic [BYTE_W-1:0] data);
		logic [CRC_W-1:0] r;
		r = acc;
		for (int k = 0; k < BYTE_W; k++) begin
			r = (r[0] ^ data[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	task automatic flag(input string what, input int unsigned want_v, input int unsigned got_v);
		fail_cnt++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		route_t              want;
		logic [CRC_W-1:0]    closed;
		logic [SLOT_W-1:0]   hit;
		logic                tgt_bank;
		if (!arst_n) begin
			route_q.delete();
			key_crc     = '0;
			live_bank   = 1'b0;
			upload_done = 1'b0;
			fail_cnt    = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// Retire the result beat against the oldest route
			if (done) begin
				if (route_q.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected result, expected none, actual slot %0h server %0h ready %0b",
						$time, slot, server, table_ready);
				end else begin
					want = route_q.pop_front();
					if (slot !== want.slot)
						flag("slot", want.slot, slot);
					if (table_ready !== want.ready)
						flag("table_ready", want.ready, table_ready);
					if (server !== want.server)
						flag("server", want.server, server);
				end
			end

			// Advance the shadow state on each accepted input beat
			if (start && !busy) begin
				case (mode)
					MODE_KEY: begin
						key_crc = fold_key_byte(key_crc, key_byte);
						if (last) begin
							closed = key_crc ^ CRC_INV;
							hit    = closed[SLOT_W-1:0];
							want.slot = hit;
							if (hit < SLOT_COUNT) begin
								want.server = slot_map[live_bank][hit];
								want.ready  = upload_done;
							end else begin
								want.server = '0;
								want.ready  = 1'b0;
							end
							route_q.push_back(want);
							key_crc = '0;
						end
					end
					MODE_WRITE: begin
						tgt_bank = upload_done ? ~live_bank : live_bank;
						if (slot_index < SLOT_COUNT)
							slot_map[tgt_bank][slot_index] = slot_value;
						if (last)
							upload_done = 1'b1;
					end
					MODE_CONFIRM: begin
						live_bank = ~live_bank;
					end
					default: begin
					end
				endcase
			end

			errors  <= fail_cnt;
			pending <= route_q.size();
		end
	end

endmodule

FILE: test/tb_crc16_key_slot_router.sv
module tb_crc16_key_slot_router;
	import cksr_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int PHASE_BEATS = 420;
	localparam int FILL_BEATS  = 64;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [MODE_W-1:0]   mode;
	logic [BYTE_W-1:0]   key_byte;
	logic                last;
	logic [SLOT_W-1:0]   slot_index;
	logic [SERVER_W-1:0] slot_value;
	logic                done;
	logic [SLOT_W-1:0]   slot;
	logic [SERVER_W-1:0] server;
	logic                table_ready;
	int                  errors;
	int                  pending;

	int idle_pct;
	int beats_sent;
	int idle_plan [3] = '{13, 46, 0};

	// Routing state as the block holds it, used to steer lookups onto written entries
	logic [CRC_W-1:0] sh_crc;
	logic             sh_live;
	logic             sh_loaded;
	bit               sh_written [2][SLOT_COUNT];

	crc16_key_slot_router u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.key_byte   (key_byte),
		.last       (last),
		.slot_index (slot_index),
		.slot_value (slot_value),
		.done       (done),
		.slot       (slot),
		.server     (server),
		.table_ready(table_ready)
	);

	crc16_key_slot_router_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.key_byte   (key_byte),
		.last       (last),
		.slot_index (slot_index),
		.slot_value (slot_value),
		.done       (done),
		.slot       (slot),
		.server     (server),
		.table_ready(table_ready),
		.errors     (errors),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	// Hold the run to a fixed budget
	initial begin
		#1000000;
		$display("[crc16_key_slot_router] ERROR");
		$finish;
	end

	// Present one beat, hold it until taken, then maybe go idle
	task automatic drive_beat(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] b,
		input logic l, input logic [SLOT_W-1:0] idx, input logic [SERVER_W-1:0] val);
		logic wb;
		start      <= 1'b1;
		mode       <= m;
		key_byte   <= b;
		last       <= l;
		slot_index <= idx;
		slot_value <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (m != MODE_UNUSED)
			beats_sent++;
		// Track the state the block now holds
		case (m)
			MODE_KEY: sh_crc = l ? '0 : crc_byte(sh_crc, b);
			MODE_WRITE: begin
				wb = sh_loaded ? !sh_live : sh_live;
				sh_written[wb][idx] = 1'b1;
				if (l)
					sh_loaded = 1'b1;
			end
			MODE_CONFIRM: sh_live = !sh_live;
			default: begin
			end
		endcase
		// Go idle, cycle by cycle, at the current idle rate
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Key beat; before a closing byte, make sure its slot holds a written entry
	task automatic drive_key(input logic [BYTE_W-1:0] b, input logic l);
		logic [CRC_W-1:0]  c;
		logic [SLOT_W-1:0] s;
		c = crc_byte(sh_crc, b) ^ CRC_INV;
		s = c[SLOT_W-1:0];
		if (l && !sh_written[sh_live][s]) begin
			drive_beat(MODE_WRITE, BYTE_W'($urandom), 1'b0, s, SERVER_W'($urandom));
			// after the first upload the write lands in staging: swap it in
			if (sh_loaded)
				drive_beat(MODE_CONFIRM, BYTE_W'($urandom), 1'($urandom),
					SLOT_W'($urandom), SERVER_W'($urandom));
		end
		drive_beat(MODE_KEY, b, l, SLOT_W'($urandom), SERVER_W'($urandom));
	endtask

	// Write a batch of random slots; close the upload on the final entry if asked
	task automatic fill_table(input logic close);
		for (int i = 0; i < FILL_BEATS; i++)
			drive_beat(MODE_WRITE, BYTE_W'($urandom), close && (i == FILL_BEATS - 1),
				SLOT_W'($urandom), SERVER_W'($urandom));
	endtask

	// Stray beat: ignored mode, table write or bank swap
	task automatic noise_beat();
		case ($urandom_range(2))
			0: drive_beat(MODE_UNUSED, BYTE_W'($urandom), 1'($urandom),
				SLOT_W'($urandom), SERVER_W'($urandom));
			1: drive_beat(MODE_WRITE, BYTE_W'($urandom), ($urandom_range(7) == 0),
				SLOT_W'($urandom), SERVER_W'($urandom));
			default: drive_beat(MODE_CONFIRM, BYTE_W'($urandom), 1'($urandom),
				SLOT_W'($urandom), SERVER_W'($urandom));
		endcase
	endtask

	// One key of random bytes, stray beats mixed in at the given rate
	task automatic send_key(input int len, input int noise_pct);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < noise_pct)
				noise_beat();
			drive_key(BYTE_W'($urandom), (i == len - 1));
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_step();
		int pick;
		pick = $urandom_range(99);
		if (pick < 65)
			send_key(($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 4), 10);
		else if (pick < 85)
			drive_beat(MODE_WRITE, BYTE_W'($urandom), ($urandom_range(7) == 0),
				SLOT_W'($urandom), SERVER_W'($urandom));
		else if (pick < 93)
			drive_beat(MODE_CONFIRM, BYTE_W'($urandom), 1'($urandom),
				SLOT_W'($urandom), SERVER_W'($urandom));
		else if (pick < 97)
			// broken key: no last, the next key runs on from here
			drive_key(BYTE_W'($urandom), 1'b0);
		else
			drive_beat(MODE_UNUSED, BYTE_W'($urandom), 1'($urandom),
				SLOT_W'($urandom), SERVER_W'($urandom));
	endtask

	initial begin
		int goal;
		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		mode       = MODE_KEY;
		key_byte   = '0;
		last       = 1'b0;
		slot_index = '0;
		slot_value = '0;
		idle_pct   = idle_plan[0];
		beats_sent = 0;
		sh_crc     = '0;
		sh_live    = 1'b0;
		sh_loaded  = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Load part of the active bank but leave the upload open
		fill_table(1'b0);

		// Keys before any upload is complete
		drive_key(8'h00, 1'b1);
		drive_key(8'hFF, 1'b1);
		drive_key(8'hA5, 1'b0);
		drive_beat(MODE_UNUSED, 8'hFF, 1'b1, '1, '1);
		drive_key(8'h5A, 1'b1);

		// Early confirm, swapped straight back
		drive_beat(MODE_CONFIRM, 8'h00, 1'b0, '0, '0);
		drive_beat(MODE_CONFIRM, 8'hFF, 1'b1, '1, '1);

		// Close the first upload on the extremes of the table
		drive_beat(MODE_WRITE, 8'h00, 1'b0, '0, 8'hFF);
		drive_beat(MODE_WRITE, 8'hFF, 1'b1, '1, 8'h00);
		drive_key(8'h00, 1'b1);
		drive_key(8'hFF, 1'b1);
		wait_drained();

		// Stage the second bank, then swap and look up in both
		fill_table(1'b1);
		send_key(3, 0);
		drive_beat(MODE_CONFIRM, 8'h3C, 1'b0, '0, '0);
		send_key(1, 0);
		send_key(8, 0);
		drive_beat(MODE_CONFIRM, 8'hC3, 1'b1, '1, '1);
		send_key(2, 0);
		drive_beat(MODE_WRITE, 8'h00, 1'b0, '0, '0);
		drive_beat(MODE_WRITE, 8'hFF, 1'b1, '1, '1);
		drive_beat(MODE_CONFIRM, 8'h00, 1'b0, '0, '0);
		send_key(4, 0);
		wait_drained();

		// Random traffic under three idle profiles
		for (int p = 0; p < 3; p++) begin
			idle_pct = idle_plan[p];
			goal = beats_sent + PHASE_BEATS;
			while (beats_sent < goal)
				random_step();
			wait_drained();
		end

		repeat (4) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[crc16_key_slot_router] OK");
		else
			$display("[crc16_key_slot_router] ERROR");
		$finish;
	end

endmodule
